// ===== src/rrl_pkg.sv =====
package rrl_pkg;

    // Default sizes
    localparam int DEF_CAPACITY = 16;
    localparam int DEF_ID_BITS  = 16;

    // Fixed field widths
    localparam int OP_W      = 2;
    localparam int VALUE_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_NEXT   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Memory read address select
    typedef enum logic [1:0] {
        RSEL_IDX      = 2'd0,
        RSEL_IDX_INC  = 2'd1,
        RSEL_IDX_INC2 = 2'd2,
        RSEL_CUR      = 2'd3
    } rsel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load_item;
        logic    rd_en;
        rsel_t   rd_sel;
        logic    idx_inc;
        logic    add_wr;
        logic    shift_wr;
        logic    hit_upd;
        logic    next_upd;
        logic    st_load;
        status_t st_code;
        logic    post;
    } rrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic match;
        logic idx_last;
        logic idx_at_fill;
        logic out_free;
    } rrl_stat_t;

endpackage

// ===== src/rrl_datapath.sv =====
module rrl_datapath #(
    parameter int CAPACITY = rrl_pkg::DEF_CAPACITY,
    parameter int ID_BITS  = rrl_pkg::DEF_ID_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [rrl_pkg::S_TDATA_W-1:0]  s_tdata,
    input  rrl_pkg::rrl_cmd_t              cmd,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [rrl_pkg::M_TDATA_W-1:0]  m_tdata,
    output rrl_pkg::rrl_stat_t             stat
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Entry memory and read data
    logic [ID_BITS-1:0] entries_reg [CAPACITY];
    logic [ID_BITS-1:0] rdata_reg;

    // Item and list state
    rrl_pkg::op_t                    op_reg;
    logic [ID_BITS-1:0]              id_reg;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [IDX_W-1:0]                cur_reg, cur_next;
    logic [CNT_W-1:0]                fill_reg, fill_next;
    logic [rrl_pkg::VALUE_W-1:0]     vout_reg;
    rrl_pkg::status_t                st_reg;

    // Output register
    logic                            out_valid_reg;
    logic [rrl_pkg::M_TDATA_W-1:0]   out_data_reg;

    logic [rrl_pkg::VALUE_W-1:0]     in_value;
    logic [CNT_W-1:0]                idx_p1, idx_p2, cur_p1;
    logic [IDX_W-1:0]                rd_addr, wr_addr;
    logic [ID_BITS-1:0]              wr_data;
    logic                            wr_en;

    assign in_value = s_tdata[rrl_pkg::OP_W +: rrl_pkg::VALUE_W];
    assign idx_p1   = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_p2   = CNT_W'(idx_reg) + CNT_W'(2);
    assign cur_p1   = CNT_W'(cur_reg) + CNT_W'(1);

    // Select read address
    always_comb
    begin
        case (cmd.rd_sel)
            rrl_pkg::RSEL_IDX:      rd_addr = idx_reg;
            rrl_pkg::RSEL_IDX_INC:  rd_addr = idx_p1[IDX_W-1:0];
            rrl_pkg::RSEL_IDX_INC2: rd_addr = idx_p2[IDX_W-1:0];
            rrl_pkg::RSEL_CUR:      rd_addr = cur_reg;
            default:                rd_addr = idx_reg;
        endcase
    end

    // Select write port: append or close the gap
    always_comb
    begin
        wr_en   = cmd.add_wr | cmd.shift_wr;
        wr_addr = cmd.add_wr ? fill_reg[IDX_W-1:0] : idx_reg;
        wr_data = cmd.add_wr ? id_reg : rdata_reg;
    end

    // Entry memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= entries_reg[rd_addr];
        end
    end

    // Next index, position and fill count
    always_comb
    begin
        idx_next  = idx_reg;
        cur_next  = cur_reg;
        fill_next = fill_reg;
        if (cmd.load_item)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc || cmd.shift_wr)
        begin
            idx_next = idx_p1[IDX_W-1:0];
        end
        if (cmd.add_wr)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        if (cmd.hit_upd)
        begin
            fill_next = fill_reg - CNT_W'(1);
            if (cur_reg == idx_reg && idx_p1 == fill_reg)
            begin
                cur_next = '0;
            end
            else if (cur_reg > idx_reg)
            begin
                cur_next = cur_reg - IDX_W'(1);
            end
            if (fill_reg == CNT_W'(1))
            begin
                cur_next = '0;
            end
        end
        if (cmd.next_upd)
        begin
            cur_next = (cur_p1 == fill_reg) ? '0 : cur_p1[IDX_W-1:0];
        end
    end

    // Hold list state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            cur_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            idx_reg  <= idx_next;
            cur_reg  <= cur_next;
            fill_reg <= fill_next;
        end
    end

    // Capture item, served value and status
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= rrl_pkg::op_t'(s_tdata[rrl_pkg::OP_W-1:0]);
            id_reg   <= ID_BITS'(in_value);
            vout_reg <= '0;
        end
        else if (cmd.next_upd)
        begin
            vout_reg <= rrl_pkg::VALUE_W'(rdata_reg);
        end
        if (cmd.st_load)
        begin
            st_reg <= cmd.st_code;
        end
    end

    // Output register: load on post, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.post)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.post)
        begin
            out_data_reg <= rrl_pkg::M_TDATA_W'({rrl_pkg::COUNT_W'(fill_reg), st_reg, vout_reg});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Status toward the controller
    always_comb
    begin
        stat.op          = op_reg;
        stat.full        = (fill_reg == CNT_W'(CAPACITY));
        stat.empty       = (fill_reg == '0);
        stat.match       = (rdata_reg == id_reg);
        stat.idx_last    = (idx_p1 == fill_reg);
        stat.idx_at_fill = (CNT_W'(idx_reg) == fill_reg);
        stat.out_free    = !out_valid_reg || m_tready;
    end

endmodule

// ===== src/rrl_ctrl.sv =====
module rrl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  rrl_pkg::rrl_stat_t stat,
    output rrl_pkg::rrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_NEXT_DATA,
        S_SCAN,
        S_SHIFT_START,
        S_SHIFT,
        S_POST
    } state_t;

    state_t state_reg, state_next;

    // Decode state into commands and next state
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.rd_sel  = rrl_pkg::RSEL_IDX;
        cmd.st_code = rrl_pkg::ST_OK;
        s_tready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.st_load = 1'b1;
                state_next  = S_POST;
                case (stat.op)
                    rrl_pkg::OP_ADD:
                    begin
                        if (stat.full)
                        begin
                            cmd.st_code = rrl_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.add_wr = 1'b1;
                        end
                    end
                    rrl_pkg::OP_REMOVE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.st_code = rrl_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = rrl_pkg::RSEL_IDX;
                            state_next = S_SCAN;
                        end
                    end
                    rrl_pkg::OP_NEXT:
                    begin
                        if (stat.empty)
                        begin
                            cmd.st_code = rrl_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = rrl_pkg::RSEL_CUR;
                            state_next = S_NEXT_DATA;
                        end
                    end
                    default:
                    begin
                        cmd.st_code = rrl_pkg::ST_OK;
                    end
                endcase
            end
            S_NEXT_DATA:
            begin
                cmd.next_upd = 1'b1;
                state_next   = S_POST;
            end
            // Compare one entry per cycle, reading the following one
            S_SCAN:
            begin
                if (stat.match)
                begin
                    cmd.hit_upd = 1'b1;
                    cmd.st_load = 1'b1;
                    state_next  = S_SHIFT_START;
                end
                else if (stat.idx_last)
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = rrl_pkg::ST_NOT_FOUND;
                    state_next  = S_POST;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = rrl_pkg::RSEL_IDX_INC;
                end
            end
            S_SHIFT_START:
            begin
                if (stat.idx_at_fill)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = rrl_pkg::RSEL_IDX_INC;
                    state_next = S_SHIFT;
                end
            end
            // Move one entry down per cycle
            S_SHIFT:
            begin
                cmd.shift_wr = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = rrl_pkg::RSEL_IDX_INC2;
                end
            end
            S_POST:
            begin
                if (stat.out_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/round_robin_list_top.sv =====
// Round-robin list: an ordered list of up to CAPACITY identifiers with a
// current position, served in turn.
// Input stream (s_axis): one transfer per operation, op 0 add, 1 remove the
// first matching entry, 2 get next. Output stream (m_axis): one result per
// operation, in order: served value, status (ok, empty, full, not found)
// and the entry count after the operation.
// Add, an unused op code, a full add and every case on an empty list pass
// from decode straight to posting the result; get next first reads the
// current entry. Remove scans the entry memory one entry per cycle and
// then moves the later entries down one per cycle. One operation is in
// work at a time.
// A new item is taken once the previous result sits in the output
// register, so the next operation runs while that result waits. If the
// receiver stalls, the finished result of the following operation waits
// inside until the output register frees.
// Reset empties the list and clears the position and the output valid;
// entry contents are not cleared and need no clearing pass.
module round_robin_list_top #(
    parameter int CAPACITY = rrl_pkg::DEF_CAPACITY,
    parameter int ID_BITS  = rrl_pkg::DEF_ID_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [1:0] op, [17:2] value, [23:18] zero
    input  logic [rrl_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [15:0] value_out, [17:16] status, [22:18] entry_count, [23] zero
    output logic [rrl_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    rrl_pkg::rrl_cmd_t  cmd;
    rrl_pkg::rrl_stat_t stat;

    // Sequencer
    rrl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // List storage and result register
    rrl_datapath #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_axis_tdata),
        .cmd      (cmd),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata),
        .stat     (stat)
    );

endmodule

// ===== sim/round_robin_list_checker.sv =====
module round_robin_list_checker #(
    parameter int CAPACITY = rrl_pkg::DEF_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // [1:0] op, [17:2] value, [23:18] zero
    input  logic [rrl_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] value_out, [17:16] status, [22:18] entry_count, [23] zero
    input  logic [rrl_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            error_count,
    output int                            results_checked,
    output int                            outstanding
);

    import rrl_pkg::*;

    // Result word as it sits on the output bus, lowest field last
    typedef struct packed {
        logic                  pad;
        logic [COUNT_W-1:0]    count;
        status_t               status;
        logic [VALUE_W-1:0]    served;
    } list_result_t;

    // Shadow copy of the list
    logic [VALUE_W-1:0] id_list [CAPACITY];
    int                 list_fill;
    int                 list_pos;

    list_result_t       expected_results[$];
    list_result_t       predicted;
    list_result_t       got;
    list_result_t       want;

    // Apply one operation to the shadow list and return the result it gives
    function automatic list_result_t apply_list_op(input op_t op, input logic [VALUE_W-1:0] id);
        list_result_t r;
        int           hit;
        r        = '0;
        r.status = ST_OK;
        case (op)
            OP_ADD:
            begin
                if (list_fill >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    id_list[list_fill] = id;
                    list_fill++;
                end
            end
            OP_REMOVE:
            begin
                hit = -1;
                for (int k = 0; k < list_fill; k++)
                    if (hit < 0 && id_list[k] == id)
                        hit = k;
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    // wrap when the current entry is also the last one
                    if (list_pos == hit && hit + 1 == list_fill)
                        list_pos = 0;
                    else if (list_pos > hit)
                        list_pos--;
                    for (int k = hit; k + 1 < list_fill; k++)
                        id_list[k] = id_list[k + 1];
                    list_fill--;
                    if (list_fill == 0)
                        list_pos = 0;
                end
            end
            OP_NEXT:
            begin
                if (list_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    if (list_pos >= list_fill)
                        list_pos = 0;
                    r.served = id_list[list_pos];
                    list_pos++;
                    if (list_pos >= list_fill)
                        list_pos = 0;
                end
            end
            default: ;
        endcase
        r.count = COUNT_W'(list_fill);
        return r;
    endfunction

    // Predict on every input transfer, compare on every output transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_fill       = 0;
            list_pos        = 0;
            error_count     = 0;
            results_checked = 0;
            outstanding     = 0;
            expected_results.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predicted = apply_list_op(op_t'(s_tdata[OP_W-1:0]),
                                          s_tdata[OP_W +: VALUE_W]);
                expected_results.insert(expected_results.size(), predicted);
            end
            if (m_tvalid && m_tready)
            begin
                got = list_result_t'(m_tdata);
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("[%0t] unexpected result: value %h status %0d count %0d",
                                 $realtime, got.served, got.status, got.count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.served !== want.served || got.status !== want.status ||
                        got.count !== want.count || got.pad !== 1'b0)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("[%0t] result mismatch: expected value %h status %0d count %0d",
                                     $realtime, want.served, want.status, want.count);
                            $display("    got value %h status %0d count %0d pad %b",
                                     got.served, got.status, got.count, got.pad);
                        end
                    end
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== sim/round_robin_list_top_test.sv =====
module round_robin_list_top_test;

    import rrl_pkg::*;

    typedef enum int {
        SINK_RANDOM,
        SINK_STEADY,
        SINK_HOLD
    } sink_mode_t;

    localparam int SINK_HOLD_CYCLES = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    int                    mismatch_count;
    int                    results_checked;
    int                    results_pending;

    sink_mode_t            sink_mode;
    logic                  sink_hold_done;
    logic                  source_steady;
    int                    sent_by_op [4];
    logic [VALUE_W-1:0]    id_pool [20];

    round_robin_list_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    round_robin_list_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_axis_tvalid),
        .s_tready        (s_axis_tready),
        .s_tdata         (s_axis_tdata),
        .m_tvalid        (m_axis_tvalid),
        .m_tready        (m_axis_tready),
        .m_tdata         (m_axis_tdata),
        .error_count     (mismatch_count),
        .results_checked (results_checked),
        .outstanding     (results_pending)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Stop a hung run
    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Output side: random stalls, a steady mode and one long hold-off
    initial
    begin
        m_axis_tready  = 1'b0;
        sink_hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_mode == SINK_HOLD && !sink_hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                sink_hold_done = 1'b1;
            end
            if (sink_mode == SINK_STEADY)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 30);
        end
    end

    // Offer one operation and hold it until the transfer
    task automatic send_op(input op_t op, input logic [VALUE_W-1:0] id);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - OP_W - VALUE_W){1'b0}}, id, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_by_op[op]++;
    endtask

    // Drop valid now and then
    task automatic source_gap();
        if (!source_steady && $urandom_range(99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Wait until every outstanding result has been taken
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    // Identifier mostly from a small pool so removes hit and duplicates occur
    function automatic logic [VALUE_W-1:0] pick_id();
        if ($urandom_range(99) < 75)
            return id_pool[$urandom_range(19)];
        return VALUE_W'($urandom());
    endfunction

    // Random operations with a given mix of add and remove
    task automatic run_mix(input int count, input int add_pct, input int remove_pct);
        int   r;
        op_t  op;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < add_pct)
                op = OP_ADD;
            else if (r < add_pct + remove_pct)
                op = OP_REMOVE;
            else if (r < 97)
                op = OP_NEXT;
            else
                op = OP_NONE;
            source_gap();
            if (op == OP_ADD || op == OP_REMOVE)
                send_op(op, pick_id());
            else
                send_op(op, VALUE_W'($urandom()));
        end
    endtask

    // Several sections, each leaning toward filling, draining or neither
    task automatic run_sections(input int sections);
        int bias;
        for (int s = 0; s < sections; s++)
        begin
            bias = $urandom_range(2);
            if (bias == 0)
                run_mix(100, 60, 15);
            else if (bias == 1)
                run_mix(100, 20, 50);
            else
                run_mix(100, 35, 30);
            if ($urandom_range(3) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        sink_mode     = SINK_RANDOM;
        source_steady = 1'b1;
        for (int k = 0; k < 4; k++)
            sent_by_op[k] = 0;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int k = 2; k < 20; k++)
            id_pool[k] = VALUE_W'($urandom());

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list cases, unused code, fill to capacity, overflow
        send_op(OP_NEXT, 16'h5A5A);
        send_op(OP_REMOVE, 16'h1234);
        send_op(OP_NONE, 16'hFFFF);
        send_op(OP_ADD, 16'h0000);
        send_op(OP_ADD, 16'hFFFF);
        for (int k = 1; k < 15; k++)
            send_op(OP_ADD, VALUE_W'(k * 16'h1111));
        send_op(OP_ADD, 16'h2222);
        // Advance twice, then remove before current, after current, and an absent id
        send_op(OP_NEXT, 16'h0000);
        send_op(OP_NEXT, 16'hFFFF);
        send_op(OP_REMOVE, 16'h0000);
        send_op(OP_REMOVE, 16'h2222);
        send_op(OP_REMOVE, 16'h1234);
        wait_drained();

        // Random traffic with idling on both sides
        source_steady = 1'b0;
        run_sections(6);

        // Stretch with no idling anywhere
        source_steady = 1'b1;
        sink_mode     = SINK_STEADY;
        run_mix(200, 35, 30);

        // Long receiver hold-off while items keep coming
        sink_mode = SINK_HOLD;
        run_mix(40, 40, 30);
        sink_mode = SINK_RANDOM;
        wait_drained();

        source_steady = 1'b0;
        run_sections(9);

        // Let the last results out
        wait_drained();
        repeat (40) @(posedge clk);

        $display("Ran %0d operations: %0d add, %0d remove, %0d get next, %0d unused code",
                 sent_by_op[OP_ADD] + sent_by_op[OP_REMOVE] + sent_by_op[OP_NEXT] +
                 sent_by_op[OP_NONE], sent_by_op[OP_ADD], sent_by_op[OP_REMOVE],
                 sent_by_op[OP_NEXT], sent_by_op[OP_NONE]);
        $display("Compared %0d results, %0d mismatching, %0d never arrived",
                 results_checked, mismatch_count, results_pending);
        if (mismatch_count == 0 && results_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== round_robin_list_top.f =====
src/rrl_pkg.sv
src/rrl_datapath.sv
src/rrl_ctrl.sv
src/round_robin_list_top.sv
sim/round_robin_list_checker.sv
sim/round_robin_list_top_test.sv
